[hdl/mpd_pkg.sv]
// Morse pulse decoder: shared types, constants and the letter lookup.
// Used by mpd_cfg_regs, mpd_step and morse_pulse_decoder_top.
// No dependencies.
`timescale 1ns / 1ps

package mpd_pkg;

  // Field and store widths
  localparam int TENTHS_W    = 12;
  localparam int CFG_W       = 12;
  localparam int CFG_IDX_W   = 3;
  localparam int CODE_W      = 7;
  localparam int MAX_SYMBOLS = 9;
  localparam int SYM_CNT_W   = $clog2(MAX_SYMBOLS + 1);
  localparam int TEXT_LIMIT  = 1024;
  localparam int CHAR_CNT_W  = 11;
  localparam int LETTERS     = 26;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  // Character codes
  localparam logic [CODE_W-1:0] CHAR_A     = 7'h41;
  localparam logic [CODE_W-1:0] CHAR_SPACE = 7'h20;
  localparam logic [CODE_W-1:0] CHAR_QMARK = 7'h3F;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIT_MIN_EXCL = 3'd0,
    REG_DIT_MAX      = 3'd1,
    REG_DAH_MAX      = 3'd2,
    REG_GAP_MIN_EXCL = 3'd3,
    REG_LETTER_GAP   = 3'd4,
    REG_WORD_GAP     = 3'd5
  } reg_idx_t;

  // Reset values of the thresholds
  localparam logic [CFG_W-1:0] RST_DIT_MIN_EXCL = 12'd5;
  localparam logic [CFG_W-1:0] RST_DIT_MAX      = 12'd15;
  localparam logic [CFG_W-1:0] RST_DAH_MAX      = 12'd35;
  localparam logic [CFG_W-1:0] RST_GAP_MIN_EXCL = 12'd15;
  localparam logic [CFG_W-1:0] RST_LETTER_GAP   = 12'd50;
  localparam logic [CFG_W-1:0] RST_WORD_GAP     = 12'd100;

  typedef struct packed {
    logic [CFG_W-1:0] dit_min_exclusive;
    logic [CFG_W-1:0] dit_max;
    logic [CFG_W-1:0] dah_max;
    logic [CFG_W-1:0] gap_min_exclusive;
    logic [CFG_W-1:0] letter_gap_max;
    logic [CFG_W-1:0] word_gap_max;
  } cfg_t;

  typedef struct packed {
    logic                pulse_level;
    logic [TENTHS_W-1:0] pulse_tenths;
  } pulse_t;

  typedef struct packed {
    logic              char_valid;
    logic [CODE_W-1:0] char_code;
    logic              symbol_ack;
    logic              message_done;
    logic              too_long;
  } result_t;

  // Morse letters A to Z: bit k is symbol k, 1 for a dah
  localparam logic [3:0] LETTER_PAT [LETTERS] = '{
    4'd2, 4'd1, 4'd5, 4'd1, 4'd0, 4'd4, 4'd3, 4'd0, 4'd0, 4'd14,
    4'd5, 4'd2, 4'd3, 4'd1, 4'd7, 4'd6, 4'd11, 4'd2, 4'd0, 4'd1,
    4'd4, 4'd8, 4'd6, 4'd9, 4'd13, 4'd3
  };
  localparam logic [2:0] LETTER_LEN [LETTERS] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4,
    3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1,
    3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };

  // Match the held symbols against every letter; '?' when none fits.
  // Bits above the count are always zero, so a whole-word compare works.
  function automatic logic [CODE_W-1:0] lookup_letter(
    input logic [MAX_SYMBOLS-1:0] bits,
    input logic [SYM_CNT_W-1:0]   cnt
  );
    logic [CODE_W-1:0] code;
    code = CHAR_QMARK;
    for (int i = 0; i < LETTERS; i++) begin
      if (cnt == SYM_CNT_W'(LETTER_LEN[i]) && bits == MAX_SYMBOLS'(LETTER_PAT[i])) begin
        code = CHAR_A + CODE_W'(i);
      end
    end
    return code;
  endfunction

endpackage

[hdl/mpd_cfg_regs.sv]
// Threshold registers of the Morse pulse decoder, written by index.
// Depends on mpd_pkg.
`timescale 1ns / 1ps

module mpd_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [mpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mpd_pkg::CFG_W-1:0]    cfg_data,
  output mpd_pkg::cfg_t                cfg
);
  import mpd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write; indexes past the list are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_DIT_MIN_EXCL: cfg_nxt.dit_min_exclusive = cfg_data;
        REG_DIT_MAX:      cfg_nxt.dit_max           = cfg_data;
        REG_DAH_MAX:      cfg_nxt.dah_max           = cfg_data;
        REG_GAP_MIN_EXCL: cfg_nxt.gap_min_exclusive = cfg_data;
        REG_LETTER_GAP:   cfg_nxt.letter_gap_max    = cfg_data;
        REG_WORD_GAP:     cfg_nxt.word_gap_max      = cfg_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dit_min_exclusive <= RST_DIT_MIN_EXCL;
      cfg_r.dit_max           <= RST_DIT_MAX;
      cfg_r.dah_max           <= RST_DAH_MAX;
      cfg_r.gap_min_exclusive <= RST_GAP_MIN_EXCL;
      cfg_r.letter_gap_max    <= RST_LETTER_GAP;
      cfg_r.word_gap_max      <= RST_WORD_GAP;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[hdl/mpd_step.sv]
// Pulse classification and decoder state: symbol store, counters, flags.
// Produces one result per pulse; state advances only when step_en is high.
// Depends on mpd_pkg.
`timescale 1ns / 1ps

module mpd_step (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  mpd_pkg::pulse_t  pulse,
  input  mpd_pkg::cfg_t    cfg,
  output mpd_pkg::result_t result
);
  import mpd_pkg::*;

  logic                   seen_r, seen_nxt;
  logic                   finished_r, finished_nxt;
  logic [MAX_SYMBOLS-1:0] sym_bits_r, sym_bits_nxt;
  logic [SYM_CNT_W-1:0]   sym_cnt_r, sym_cnt_nxt;
  logic [CHAR_CNT_W-1:0]  char_cnt_r, char_cnt_nxt;
  logic                   is_dah;
  result_t                res;

  assign is_dah = (pulse.pulse_tenths > cfg.dit_max);

  // Classify the pulse and work out the next state
  always_comb begin
    seen_nxt     = seen_r;
    finished_nxt = finished_r;
    sym_bits_nxt = sym_bits_r;
    sym_cnt_nxt  = sym_cnt_r;
    char_cnt_nxt = char_cnt_r;
    res          = '0;
    if (!finished_r && (pulse.pulse_level || seen_r)) begin
      if (pulse.pulse_level) begin
        seen_nxt = 1'b1;
        if (pulse.pulse_tenths > cfg.dit_min_exclusive &&
            pulse.pulse_tenths <= cfg.dah_max) begin
          res.symbol_ack = 1'b1;
          // store while there is room, otherwise only acknowledge
          if (sym_cnt_r < SYM_CNT_W'(MAX_SYMBOLS)) begin
            sym_bits_nxt = sym_bits_r | (MAX_SYMBOLS'(is_dah) << sym_cnt_r);
            sym_cnt_nxt  = sym_cnt_r + SYM_CNT_W'(1);
          end
        end
      end else if (pulse.pulse_tenths > cfg.gap_min_exclusive) begin
        if (pulse.pulse_tenths <= cfg.letter_gap_max) begin
          res.char_valid = 1'b1;
          res.char_code  = lookup_letter(sym_bits_r, sym_cnt_r);
        end else if (pulse.pulse_tenths <= cfg.word_gap_max) begin
          res.char_valid = 1'b1;
          res.char_code  = CHAR_SPACE;
        end else begin
          res.message_done = 1'b1;
          finished_nxt     = 1'b1;
        end
        // a character drops the pending symbols and counts toward the limit
        if (res.char_valid) begin
          sym_bits_nxt = '0;
          sym_cnt_nxt  = '0;
          char_cnt_nxt = char_cnt_r + CHAR_CNT_W'(1);
          if (char_cnt_nxt >= CHAR_CNT_W'(TEXT_LIMIT)) begin
            res.message_done = 1'b1;
            res.too_long     = 1'b1;
            finished_nxt     = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r     <= 1'b0;
      finished_r <= 1'b0;
      sym_bits_r <= '0;
      sym_cnt_r  <= '0;
      char_cnt_r <= '0;
    end else if (step_en) begin
      seen_r     <= seen_nxt;
      finished_r <= finished_nxt;
      sym_bits_r <= sym_bits_nxt;
      sym_cnt_r  <= sym_cnt_nxt;
      char_cnt_r <= char_cnt_nxt;
    end
  end

  assign result = res;

endmodule

[hdl/morse_pulse_decoder_top.sv]
// Morse pulse decoder top level: input register, decode step, result register.
// Depends on mpd_pkg, mpd_cfg_regs and mpd_step.
`timescale 1ns / 1ps
//
// Usage:
//   in_*   : one word per key pulse (level and length in tenths of a second).
//   out_*  : exactly one result word per pulse, in order. out_tlast marks
//            the word that finishes the message (end gap or text limit).
//   cfg_*  : threshold writes by index; the user keeps them to an idle stream (not enforced).
// Path: an accepted pulse is held in the input register, decoded, and its
//   result held in the result register, which drives out_*.
// Throughput: one pulse per cycle while out_tready is high; the symbol store,
//   counters and letter match all update between the two registers.
// Stall: when out_tready is low the result register holds; the input
//   register still takes one more word if it is empty, then in_tready drops
//   until the result is taken.
// Reset: rst_n low clears the valid flags of both registers and the decoder
//   state, and restores the threshold reset values. After a message finishes,
//   every further pulse gives an all-zero result until the next reset.

module morse_pulse_decoder_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // tdata: [0] pulse_level, [12:1] pulse_tenths, [15:13] zero
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [mpd_pkg::IN_TDATA_W-1:0]  in_tdata,
  // tdata: [0] char_valid, [7:1] char_code, [8] symbol_ack, [9] too_long,
  //        [15:10] zero; tlast: message_done
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [mpd_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast,
  input  logic                            cfg_we,
  input  logic [mpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mpd_pkg::CFG_W-1:0]       cfg_data
);
  import mpd_pkg::*;

  cfg_t    cfg;
  pulse_t  in_word;
  pulse_t  s1_word_r;
  logic    s1_valid_r;
  logic    out_valid_r;
  result_t out_res_r;
  result_t step_res;
  logic    s2_load;
  logic    in_fire;

  // Unpack the input word
  assign in_word.pulse_level  = in_tdata[0];
  assign in_word.pulse_tenths = in_tdata[TENTHS_W:1];

  // Advance when the result register is free or being drained
  assign s2_load   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s2_load;
  assign in_fire   = in_tvalid && in_tready;

  mpd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mpd_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s2_load),
    .pulse   (s1_word_r),
    .cfg     (cfg),
    .result  (step_res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_word_r <= in_word;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      out_res_r <= step_res;
    end
  end

  // Pack the result word
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_res_r.message_done;
  assign out_tdata  = {6'b0, out_res_r.too_long, out_res_r.symbol_ack,
                       out_res_r.char_code, out_res_r.char_valid};

endmodule

[sim/morse_pulse_decoder_top_test.sv]
// Self-checking testbench for morse_pulse_decoder_top: directed pulse edge cases,
// then random key traffic over several threshold settings, then the character limit.
// Depends on mpd_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module morse_pulse_decoder_top_test;
  import mpd_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_TARGET = 360;
  localparam int TENTHS_MAX    = (1 << TENTHS_W) - 1;

  // Register indexes past the last threshold; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] SPARE_IDX_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] SPARE_IDX_HI = 3'd7;

  // Threshold settings swept by the random traffic
  localparam int PHASE_RESET    = 0;
  localparam int PHASE_WIDE     = 1;
  localparam int PHASE_TIGHT    = 2;
  localparam int PHASE_ALL_ZERO = 3;
  localparam int PHASE_ALL_MAX  = 4;
  localparam int PHASE_SKEWED   = 5;

  typedef enum int {PK_DIT, PK_DAH, PK_LETTER_GAP, PK_WORD_GAP, PK_ANY_HIGH, PK_ANY_LOW}
    pulse_kind_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // tdata: [0] pulse_level, [12:1] pulse_tenths, [15:13] zero
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // tdata: [0] char_valid, [7:1] char_code, [8] symbol_ack, [9] too_long; tlast: message_done
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  morse_pulse_decoder_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Morse alphabet, A first
  string letter_spellings [LETTERS] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---", "-.-", ".-..",
    "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-", "..-", "...-", ".--", "-..-",
    "-.--", "--.."
  };

  // Decoder shadow state and thresholds
  cfg_t                  thr;
  logic                  dec_seen_press = 1'b0;
  logic                  dec_finished = 1'b0;
  logic [MAX_SYMBOLS-1:0] dec_sym_bits = '0;
  int                    dec_sym_cnt = 0;
  logic [CHAR_CNT_W-1:0] dec_char_count = '0;

  result_t expected_decodes [$];
  result_t got_word;
  result_t want_word;
  int      mismatch_count = 0;
  int      pulses_sent = 0;
  int      cycle_count = 0;
  bit      sender_paced = 1'b1;
  bit      receiver_paced = 1'b1;

  function automatic cfg_t reset_thresholds();
    cfg_t c;
    c.dit_min_exclusive = RST_DIT_MIN_EXCL;
    c.dit_max           = RST_DIT_MAX;
    c.dah_max           = RST_DAH_MAX;
    c.gap_min_exclusive = RST_GAP_MIN_EXCL;
    c.letter_gap_max    = RST_LETTER_GAP;
    c.word_gap_max      = RST_WORD_GAP;
    return c;
  endfunction

  // Spell the held symbols and search the alphabet; no match gives a question mark
  function automatic logic [CODE_W-1:0] letter_for_symbols();
    string spelled;
    spelled = "";
    for (int k = 0; k < dec_sym_cnt; k++) begin
      if (dec_sym_bits[k]) spelled = {spelled, "-"};
      else spelled = {spelled, "."};
    end
    for (int i = 0; i < LETTERS; i++) begin
      if (spelled == letter_spellings[i]) return CHAR_A + CODE_W'(i);
    end
    return CHAR_QMARK;
  endfunction

  // Advance the shadow decoder by one pulse and return the word it must produce
  function automatic result_t decode_pulse(pulse_t p);
    result_t r;
    r = '0;
    if (!dec_finished && (p.pulse_level || dec_seen_press)) begin
      if (p.pulse_level) begin
        dec_seen_press = 1'b1;
        if (p.pulse_tenths > thr.dit_min_exclusive && p.pulse_tenths <= thr.dah_max) begin
          r.symbol_ack = 1'b1;
          if (dec_sym_cnt < MAX_SYMBOLS) begin
            dec_sym_bits[dec_sym_cnt] = (p.pulse_tenths > thr.dit_max);
            dec_sym_cnt++;
          end
        end
      end else if (p.pulse_tenths > thr.gap_min_exclusive) begin
        if (p.pulse_tenths <= thr.letter_gap_max) begin
          r.char_valid = 1'b1;
          r.char_code  = letter_for_symbols();
        end else if (p.pulse_tenths <= thr.word_gap_max) begin
          r.char_valid = 1'b1;
          r.char_code  = CHAR_SPACE;
        end else begin
          r.message_done = 1'b1;
          dec_finished   = 1'b1;
        end
        if (r.char_valid) begin
          dec_sym_bits   = '0;
          dec_sym_cnt    = 0;
          dec_char_count = dec_char_count + 1'b1;
          if (dec_char_count >= CHAR_CNT_W'(TEXT_LIMIT)) begin
            r.message_done = 1'b1;
            r.too_long     = 1'b1;
            dec_finished   = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic bit kind_is_high(pulse_kind_t kind);
    return kind == PK_DIT || kind == PK_DAH || kind == PK_ANY_HIGH;
  endfunction

  // Draw a length that lands in the class under the current thresholds, with the
  // class edges favored; fall back to any length when the class is empty. Low
  // lengths never go past the end-gap bound, so a message cannot end by accident.
  function automatic int draw_tenths(pulse_kind_t kind);
    int lo;
    int hi;
    int low_ceiling;
    int gap_floor;
    low_ceiling = (thr.gap_min_exclusive > thr.word_gap_max) ?
                  int'(thr.gap_min_exclusive) : int'(thr.word_gap_max);
    gap_floor   = (thr.gap_min_exclusive > thr.letter_gap_max) ?
                  int'(thr.gap_min_exclusive) : int'(thr.letter_gap_max);
    case (kind)
      PK_DIT: begin
        lo = int'(thr.dit_min_exclusive) + 1;
        hi = (thr.dit_max < thr.dah_max) ? int'(thr.dit_max) : int'(thr.dah_max);
      end
      PK_DAH: begin
        lo = ((thr.dit_max > thr.dit_min_exclusive) ?
              int'(thr.dit_max) : int'(thr.dit_min_exclusive)) + 1;
        hi = int'(thr.dah_max);
      end
      PK_LETTER_GAP: begin
        lo = int'(thr.gap_min_exclusive) + 1;
        hi = int'(thr.letter_gap_max);
      end
      PK_WORD_GAP: begin
        lo = gap_floor + 1;
        hi = int'(thr.word_gap_max);
      end
      PK_ANY_HIGH: begin
        lo = 0;
        hi = TENTHS_MAX;
      end
      default: begin
        lo = 0;
        hi = low_ceiling;
      end
    endcase
    if (lo > hi) begin
      if (kind_is_high(kind)) return int'($urandom_range(0, TENTHS_MAX));
      return int'($urandom_range(0, low_ceiling));
    end
    case ($urandom_range(0, 7))
      0:       return lo;
      1:       return hi;
      default: return int'($urandom_range(lo, hi));
    endcase
  endfunction

  function automatic cfg_t pick_thresholds(int phase);
    cfg_t c;
    int   a;
    int   b;
    case (phase)
      PHASE_RESET: c = reset_thresholds();
      PHASE_WIDE: begin
        c = '{dit_min_exclusive: 12'd0, dit_max: 12'd2047, dah_max: 12'd4095,
              gap_min_exclusive: 12'd0, letter_gap_max: 12'd2047, word_gap_max: 12'd4095};
      end
      PHASE_TIGHT: begin
        c = '{dit_min_exclusive: 12'd1, dit_max: 12'd2, dah_max: 12'd3,
              gap_min_exclusive: 12'd1, letter_gap_max: 12'd2, word_gap_max: 12'd3};
      end
      PHASE_ALL_ZERO: c = '0;
      PHASE_ALL_MAX:  c = '1;
      PHASE_SKEWED: begin
        // every long-enough press is a dah, every real gap a letter gap
        c = '{dit_min_exclusive: 12'd0, dit_max: 12'd0, dah_max: 12'd4095,
              gap_min_exclusive: 12'd0, letter_gap_max: 12'd4095, word_gap_max: 12'd4095};
      end
      default: begin
        if ($urandom_range(0, 3) == 0) begin
          // thresholds in any order
          c.dit_min_exclusive = CFG_W'($urandom_range(0, 120));
          c.dit_max           = CFG_W'($urandom_range(0, 120));
          c.dah_max           = CFG_W'($urandom_range(0, 120));
          c.gap_min_exclusive = CFG_W'($urandom_range(0, 120));
          c.letter_gap_max    = CFG_W'($urandom_range(0, 120));
          c.word_gap_max      = CFG_W'($urandom_range(0, 120));
        end else begin
          a = $urandom_range(0, 40);
          b = a + $urandom_range(1, 40);
          c.dit_min_exclusive = CFG_W'(a);
          c.dit_max           = CFG_W'(b);
          c.dah_max           = CFG_W'(b + $urandom_range(1, 60));
          a = $urandom_range(0, 40);
          b = a + $urandom_range(1, 60);
          c.gap_min_exclusive = CFG_W'(a);
          c.letter_gap_max    = CFG_W'(b);
          c.word_gap_max      = CFG_W'(b + $urandom_range(1, 100));
        end
      end
    endcase
    return c;
  endfunction

  function automatic void shuffle_pacing();
    sender_paced   = ($urandom_range(0, 2) != 0);
    receiver_paced = ($urandom_range(0, 2) != 0);
  endfunction

  task automatic note_mismatch(input string what, input int want, input int got);
    mismatch_count++;
    $display("[%0t] %s: expected %0h, actual %0h", $time, what, want, got);
  endtask

  // Send one pulse word and record what it must decode to once accepted
  task automatic key_pulse(input logic level, input int tenths);
    pulse_t p;
    int     gap;
    p.pulse_level  = level;
    p.pulse_tenths = TENTHS_W'(tenths);
    gap = sender_paced ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'({p.pulse_tenths, p.pulse_level});
    do @(posedge clk); while (!in_tready);
    expected_decodes.push_back(decode_pulse(p));
    pulses_sent++;
  endtask

  task automatic key_kind(input pulse_kind_t kind);
    key_pulse(kind_is_high(kind), draw_tenths(kind));
  endtask

  // Hold the input idle until every pending result has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_decodes.size() != 0) @(posedge clk);
  endtask

  // Write all thresholds while idle, then poke the unused indexes
  task automatic apply_thresholds(input cfg_t c);
    reg_idx_t         order [6] = '{REG_DIT_MIN_EXCL, REG_DIT_MAX, REG_DAH_MAX,
                                    REG_GAP_MIN_EXCL, REG_LETTER_GAP, REG_WORD_GAP};
    logic [CFG_W-1:0] value [6];
    value = '{c.dit_min_exclusive, c.dit_max, c.dah_max,
              c.gap_min_exclusive, c.letter_gap_max, c.word_gap_max};
    wait_drained();
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= order[i];
      cfg_data  <= value[i];
      @(posedge clk);
    end
    cfg_index <= SPARE_IDX_LO;
    cfg_data  <= CFG_W'($urandom);
    @(posedge clk);
    cfg_index <= SPARE_IDX_HI;
    cfg_data  <= CFG_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    thr = c;
  endtask

  // A letter from the alphabet, or now and then a random pattern that may be
  // empty or overfill the store, closed by a gap
  task automatic send_random_word();
    string pattern;
    int    n;
    if ($urandom_range(0, 6) == 0) begin
      pattern = "";
      n = $urandom_range(0, 11);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 1) == 1) pattern = {pattern, "-"};
        else pattern = {pattern, "."};
      end
    end else begin
      pattern = letter_spellings[$urandom_range(0, LETTERS - 1)];
    end
    for (int k = 0; k < pattern.len(); k++) begin
      if ($urandom_range(0, 19) == 0) key_kind(PK_ANY_HIGH);
      key_kind((pattern[k] == "-") ? PK_DAH : PK_DIT);
    end
    key_kind(($urandom_range(0, 4) == 0) ? PK_WORD_GAP : PK_LETTER_GAP);
  endtask

  // Releases before any press are dropped; a typo press still counts as the first
  task automatic test_before_first_press();
    key_pulse(1'b0, 30);
    key_pulse(1'b0, TENTHS_MAX);
    key_pulse(1'b0, 0);
    key_pulse(1'b1, 0);
    key_pulse(1'b0, 16);
  endtask

  // Class boundaries at reset thresholds, letters, word gap dropping symbols
  task automatic test_threshold_edges();
    key_pulse(1'b1, 5);
    key_pulse(1'b1, 6);
    key_pulse(1'b1, 36);
    key_pulse(1'b1, 35);
    key_pulse(1'b0, 15);
    key_pulse(1'b0, 50);
    key_pulse(1'b1, 15);
    key_pulse(1'b1, 16);
    key_pulse(1'b1, TENTHS_MAX);
    key_pulse(1'b1, 15);
    key_pulse(1'b0, 16);
    key_pulse(1'b1, 10);
    key_pulse(1'b0, 51);
    key_pulse(1'b0, 100);
    key_pulse(1'b0, 30);
  endtask

  // Presses past a full store are acknowledged but not kept
  task automatic test_full_store();
    repeat (MAX_SYMBOLS + 1) key_pulse(1'b1, 20);
    key_pulse(1'b0, 30);
  endtask

  task automatic test_random_traffic();
    cfg_t c;
    int   phase;
    int   quota;
    int   next_shuffle;
    phase = PHASE_RESET;
    next_shuffle = 0;
    while (pulses_sent < RANDOM_TARGET && int'(dec_char_count) < TEXT_LIMIT - 64) begin
      c = pick_thresholds(phase);
      apply_thresholds(c);
      quota = pulses_sent + ((phase == PHASE_ALL_ZERO || phase == PHASE_ALL_MAX) ? 20 : 40);
      while (pulses_sent < quota && int'(dec_char_count) < TEXT_LIMIT - 64) begin
        if (pulses_sent >= next_shuffle) begin
          shuffle_pacing();
          next_shuffle = pulses_sent + 40;
        end
        if ($urandom_range(0, 99) < 70) send_random_word();
        else key_kind(($urandom_range(0, 1) == 1) ? PK_ANY_HIGH : PK_ANY_LOW);
      end
      phase++;
    end
  endtask

  // Fill the text up to its limit, then check that further pulses are ignored
  task automatic test_text_limit();
    apply_thresholds(reset_thresholds());
    while (!dec_finished) begin
      if ($urandom_range(0, 49) == 0) shuffle_pacing();
      if ($urandom_range(0, 7) == 0)
        key_kind(($urandom_range(0, 1) == 1) ? PK_DAH : PK_DIT);
      else
        key_kind(($urandom_range(0, 3) == 0) ? PK_WORD_GAP : PK_LETTER_GAP);
    end
    key_pulse(1'b1, 10);
    key_pulse(1'b0, 30);
    key_pulse(1'b0, TENTHS_MAX);
  endtask

  // Result side: when receiver pacing is on, hold out_tready low for a random stall before each word
  initial begin
    int gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = receiver_paced ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Compare every accepted result word with the oldest pending prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_word.char_valid   = out_tdata[0];
      got_word.char_code    = out_tdata[7:1];
      got_word.symbol_ack   = out_tdata[8];
      got_word.too_long     = out_tdata[9];
      got_word.message_done = out_tlast;
      if (expected_decodes.size() == 0) begin
        note_mismatch("result with nothing pending", 0, int'(out_tdata));
      end else begin
        want_word = expected_decodes.pop_front();
        if (got_word.char_valid != want_word.char_valid)
          note_mismatch("char_valid", want_word.char_valid, got_word.char_valid);
        if (got_word.char_code != want_word.char_code)
          note_mismatch("char_code", want_word.char_code, got_word.char_code);
        if (got_word.symbol_ack != want_word.symbol_ack)
          note_mismatch("symbol_ack", want_word.symbol_ack, got_word.symbol_ack);
        if (got_word.message_done != want_word.message_done)
          note_mismatch("message_done", want_word.message_done, got_word.message_done);
        if (got_word.too_long != want_word.too_long)
          note_mismatch("too_long", want_word.too_long, got_word.too_long);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    thr = reset_thresholds();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_before_first_press();
    test_threshold_edges();
    test_full_store();
    test_random_traffic();
    test_text_limit();
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_decodes.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
